/* rtl/dhte_pkg.sv */
// shared types, codes and constants for the double hash table engine
// no dependencies; imported by the top level
package dhte_pkg;

  localparam int CFG_W  = 11;   // width of the table_size and probe_limit registers
  localparam int SLOT_W = 10;   // width of the reported slot index

  localparam logic [CFG_W-1:0] TABLE_SIZE_RST  = 11'd1024;
  localparam logic [CFG_W-1:0] PROBE_LIMIT_RST = 11'd1024;

  // register index, taken from paddr[2]
  localparam logic REG_TABLE_SIZE  = 1'b0;
  localparam logic REG_PROBE_LIMIT = 1'b1;

  // command codes
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  typedef enum logic [1:0] {
    STAT_STORED    = 2'd0,
    STAT_FOUND     = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_FULL      = 2'd3
  } status_t;

  // one prime per power-of-two band of the table size
  localparam logic [31:0] BAND_PRIMES [0:30] = '{
    32'd2, 32'd3, 32'd5, 32'd7, 32'd23, 32'd53, 32'd97, 32'd193, 32'd389,
    32'd769, 32'd1543, 32'd3079, 32'd6151, 32'd12289, 32'd24593, 32'd49157,
    32'd98317, 32'd196613, 32'd393241, 32'd786433, 32'd1572869, 32'd3145739,
    32'd6291469, 32'd12582917, 32'd25165843, 32'd50331653, 32'd100663319,
    32'd201326611, 32'd402653189, 32'd805306457, 32'd1610612741
  };

  // band n is the smallest n >= 1 with 2^n <= s <= 2^(n+1), i.e. max(1, msb(s-1));
  // a size of one gives prime 1 (the step is zero mod 1 anyway)
  function automatic logic [31:0] band_prime(input logic [31:0] s);
    logic [31:0] sm1;
    logic [4:0]  n;
    sm1 = s - 32'd1;
    n   = 5'd0;
    for (int b = 0; b < 31; b++) begin
      if (sm1[b]) begin
        n = 5'(b);
      end
    end
    if (n == 5'd0) begin
      n = 5'd1;
    end
    if (s < 32'd2) begin
      return 32'd1;
    end
    return BAND_PRIMES[n - 5'd1];
  endfunction

endpackage

/* rtl/dhte_ram.sv */
// generic single write port, single read port ram with registered read
// no dependencies
module dhte_ram #(
  parameter int WIDTH = 65,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/dhte_rem_unit.sv */
// iterative restoring remainder unit, one dividend bit per cycle
// no dependencies; used by the top level for key mod size and key mod prime
module dhte_rem_unit #(
  parameter int KW = 32,   // dividend width
  parameter int DW = 11    // divisor and remainder width
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [KW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] rem
);

  localparam int CW = $clog2(KW + 1);

  logic          busy_r;
  logic          done_r;
  logic [CW-1:0] cnt_r;
  logic [KW-1:0] dvd_r;
  logic [DW-1:0] div_r;
  logic [DW-1:0] rem_r;
  logic [DW:0]   trial;
  logic [DW-1:0] rem_nxt;

  // shift in the next dividend bit, subtract when it fits
  always_comb begin
    trial = {rem_r, dvd_r[KW-1]};
    if (trial >= {1'b0, div_r}) begin
      rem_nxt = DW'(trial - {1'b0, div_r});
    end else begin
      rem_nxt = DW'(trial);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      // pulse once the last dividend bit has been shifted in
      done_r <= busy_r && !start && (cnt_r == CW'(1));
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(KW);
        dvd_r  <= dividend;
        div_r  <= divisor;
        rem_r  <= '0;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        dvd_r <= {dvd_r[KW-2:0], 1'b0};
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

/* rtl/double_hash_table_engine.sv */
// top level of the double hash table engine: sequencer, probe arithmetic, cfg port
// depends on dhte_pkg, dhte_rem_unit and dhte_ram
//
//   port group  dir   handshake            beat contents
//   in_*        in    in_valid/in_ready    command, key, payload
//   out_*       out   out_valid/out_ready  status, slot, payload_out
//   cfg_*       in    apb psel/penable     table_size (0x0), probe_limit (0x4)
//
// after reset a clearing pass writes every slot empty; no item is taken until it ends
// one item runs two passes of the bit-serial remainder unit (key mod size, key mod
// prime), then for each probe the registered slot memory read and the check
// a new item is taken while the previous result still waits on out_ready
// a finished result holds the sequencer until the output register frees up
module double_hash_table_engine
  import dhte_pkg::*;
#(
  parameter int CAPACITY     = 1024,
  parameter int KEY_BITS     = 32,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // input channel
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_command,
  input  logic [KEY_BITS-1:0]     in_key,
  input  logic [PAYLOAD_BITS-1:0] in_payload,
  // result channel
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [1:0]              out_status,
  output logic [SLOT_W-1:0]       out_slot,
  output logic [PAYLOAD_BITS-1:0] out_payload_out,
  // configuration port
  input  logic                    cfg_psel,
  input  logic                    cfg_penable,
  input  logic                    cfg_pwrite,
  input  logic [2:0]              cfg_paddr,
  input  logic [31:0]             cfg_pwdata,
  output logic [31:0]             cfg_prdata,
  output logic                    cfg_pready
);

  localparam int AW = $clog2(CAPACITY);       // slot address width
  localparam int DW = $clog2(CAPACITY + 1);   // width of size, prime and probe values
  localparam int RW = 1 + KEY_BITS + PAYLOAD_BITS;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD,
    ST_DIV_S,
    ST_DIV_P,
    ST_READ,
    ST_CHECK,
    ST_DONE
  } state_t;

  state_t                 state_r;
  logic [CFG_W-1:0]       cfg_table_size_r;
  logic [CFG_W-1:0]       cfg_probe_limit_r;
  logic [AW-1:0]          clr_r;

  // latched item
  logic                   cmd_r;
  logic [KEY_BITS-1:0]    key_r;
  logic [PAYLOAD_BITS-1:0] pay_r;

  // probe state
  logic [DW-1:0]          s_r;
  logic [DW-1:0]          prime_r;
  logic [CFG_W-1:0]       lim_r;
  logic [DW-1:0]          h_r;
  logic [DW-1:0]          step_r;
  logic [DW-1:0]          inc_r;
  logic [CFG_W-1:0]       i_r;

  // pending result and output register
  status_t                res_status_r;
  logic [SLOT_W-1:0]      res_slot_r;
  logic [PAYLOAD_BITS-1:0] res_pay_r;
  logic                   out_valid_r;
  status_t                out_status_r;
  logic [SLOT_W-1:0]      out_slot_r;
  logic [PAYLOAD_BITS-1:0] out_pay_r;

  // size and limit as the sequencer sees them
  logic [31:0]            ts32;
  logic [31:0]            s32;
  logic [DW-1:0]          s_eff;
  logic [DW-1:0]          prime_eff;
  logic [CFG_W-1:0]       lim_eff;

  // remainder unit hookup
  logic                   rem_start;
  logic [DW-1:0]          rem_divisor;
  logic                   rem_done;
  logic [DW-1:0]          rem_q;

  // slot memory: {valid, key, payload}
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [RW-1:0]          ram_wdata;
  logic [RW-1:0]          ram_rdata;
  logic                   slot_valid;
  logic [KEY_BITS-1:0]    slot_key;
  logic [PAYLOAD_BITS-1:0] slot_pay;

  logic                   cfg_wr;
  logic                   out_free;
  logic                   hit;
  logic [DW-1:0]          diff;
  logic [DW-1:0]          step_nxt;
  logic [DW-1:0]          h_nxt;
  logic [DW-1:0]          inc_nxt;
  logic [31:0]            h32;

  // (a + b) mod m for a, b < m
  function automatic logic [DW-1:0] mod_add(input logic [DW-1:0] a,
                                            input logic [DW-1:0] b,
                                            input logic [DW-1:0] m);
    logic [DW:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= {1'b0, m}) begin
      sum = sum - {1'b0, m};
    end
    return DW'(sum);
  endfunction

  // zero size acts as one, sizes above the slot count clamp to it
  always_comb begin
    ts32 = 32'(cfg_table_size_r);
    if (ts32 == 32'd0) begin
      s32 = 32'd1;
    end else if (ts32 > 32'(CAPACITY)) begin
      s32 = 32'(CAPACITY);
    end else begin
      s32 = ts32;
    end
  end

  assign s_eff     = DW'(s32);
  assign prime_eff = DW'(band_prime(s32));   // the band prime never exceeds the size
  assign lim_eff   = (cfg_probe_limit_r == '0) ? CFG_W'(1) : cfg_probe_limit_r;

  // apb port, always ready, address bit 2 picks the register
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[2] == REG_PROBE_LIMIT) ? 32'(cfg_probe_limit_r)
                                                        : 32'(cfg_table_size_r);

  // key mod size first, then key mod prime
  assign rem_start   = (state_r == ST_LOAD) || (state_r == ST_DIV_S && rem_done);
  assign rem_divisor = (state_r == ST_LOAD) ? s_eff : prime_r;

  dhte_rem_unit #(
    .KW (KEY_BITS),
    .DW (DW)
  ) u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rem_start),
    .dividend (key_r),
    .divisor  (rem_divisor),
    .done     (rem_done),
    .rem      (rem_q)
  );

  // step = (prime - key mod prime) mod size; the difference is at most the size
  assign diff     = prime_r - rem_q;
  assign step_nxt = (diff == s_r) ? '0 : diff;

  assign slot_valid = ram_rdata[RW-1];
  assign slot_key   = ram_rdata[RW-2 -: KEY_BITS];
  assign slot_pay   = ram_rdata[PAYLOAD_BITS-1:0];

  // insert wants an empty slot, lookup a valid slot with the same key
  assign hit = (cmd_r == CMD_INSERT) ? !slot_valid : (slot_valid && slot_key == key_r);

  // next probe: h + (i*step mod s), with the increment kept reduced
  assign h_nxt   = mod_add(h_r, inc_r, s_r);
  assign inc_nxt = mod_add(inc_r, step_r, s_r);
  assign h32     = 32'(h_r);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = h_r[AW-1:0];
    ram_wdata = {1'b1, key_r, pay_r};
    if (state_r == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_r;
      ram_wdata = '0;
    end else if (state_r == ST_CHECK && cmd_r == CMD_INSERT && !slot_valid) begin
      ram_we = 1'b1;
    end
  end

  dhte_ram #(
    .WIDTH (RW),
    .DEPTH (CAPACITY)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (h_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign in_ready = (state_r == ST_IDLE);
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r           <= ST_CLEAR;
      clr_r             <= '0;
      cfg_table_size_r  <= TABLE_SIZE_RST;
      cfg_probe_limit_r <= PROBE_LIMIT_RST;
      out_valid_r       <= 1'b0;
    end else begin
      if (cfg_wr) begin
        if (cfg_paddr[2] == REG_TABLE_SIZE) begin
          cfg_table_size_r <= cfg_pwdata[CFG_W-1:0];
        end else begin
          cfg_probe_limit_r <= cfg_pwdata[CFG_W-1:0];
        end
      end

      // the done state reloads the output register itself
      if (out_valid_r && out_ready && state_r != ST_DONE) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_CLEAR: begin
          // one slot per cycle marked empty
          clr_r <= clr_r + AW'(1);
          if (clr_r == AW'(CAPACITY - 1)) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            cmd_r   <= in_command;
            key_r   <= in_key;
            pay_r   <= in_payload;
            state_r <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          s_r     <= s_eff;
          prime_r <= prime_eff;
          lim_r   <= lim_eff;
          state_r <= ST_DIV_S;
        end
        ST_DIV_S: begin
          if (rem_done) begin
            h_r     <= rem_q;
            state_r <= ST_DIV_P;
          end
        end
        ST_DIV_P: begin
          if (rem_done) begin
            step_r  <= step_nxt;
            inc_r   <= step_nxt;
            i_r     <= CFG_W'(1);
            state_r <= ST_READ;
          end
        end
        ST_READ: begin
          // slot memory read in flight
          state_r <= ST_CHECK;
        end
        ST_CHECK: begin
          if (hit) begin
            res_status_r <= (cmd_r == CMD_INSERT) ? STAT_STORED : STAT_FOUND;
            res_slot_r   <= h32[SLOT_W-1:0];
            res_pay_r    <= (cmd_r == CMD_INSERT) ? '0 : slot_pay;
            state_r      <= ST_DONE;
          end else if (i_r == lim_r) begin
            res_status_r <= (cmd_r == CMD_INSERT) ? STAT_FULL : STAT_NOT_FOUND;
            res_slot_r   <= '0;
            res_pay_r    <= '0;
            state_r      <= ST_DONE;
          end else begin
            h_r     <= h_nxt;
            inc_r   <= inc_nxt;
            i_r     <= i_r + CFG_W'(1);
            state_r <= ST_READ;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_slot_r   <= res_slot_r;
            out_pay_r    <= res_pay_r;
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_slot        = out_slot_r;
  assign out_payload_out = out_pay_r;

endmodule

/* tb/sv/double_hash_table_engine_tb.sv */
`timescale 1ns / 1ps
// self-checking testbench for the double hash table engine: inserts and lookups with
// random stalls on both channels, predicted against a behavioral table model
// depends on dhte_pkg and double_hash_table_engine
module double_hash_table_engine_tb;
  import dhte_pkg::*;

  localparam int CAPACITY       = 1024;
  localparam int RX_HOLD_CYCLES = 600;   // long receiver hold-off, fills the block up

  // one table operation as offered on the input channel
  typedef struct packed {
    logic        cmd;
    logic [31:0] key;
    logic [31:0] data;
  } table_op_t;

  // one reply as seen on the result channel
  typedef struct packed {
    status_t           status;
    logic [SLOT_W-1:0] slot;
    logic [31:0]       data;
  } table_reply_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // input channel, driven on the falling edge
  logic        in_valid   = 1'b0;
  logic        in_ready;
  logic        in_command = CMD_INSERT;
  logic [31:0] in_key     = '0;
  logic [31:0] in_payload = '0;

  // result channel
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [1:0]        out_status;
  logic [SLOT_W-1:0] out_slot;
  logic [31:0]       out_payload_out;

  // register port
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // shadow of the block: register copies and the slot array
  logic [CFG_W-1:0] cur_size  = TABLE_SIZE_RST;
  logic [CFG_W-1:0] cur_limit = PROBE_LIMIT_RST;
  bit               tbl_valid [CAPACITY];
  logic [31:0]      tbl_key   [CAPACITY];
  logic [31:0]      tbl_data  [CAPACITY];

  table_op_t    queued_ops [$];   // ops waiting for the driver
  table_reply_t due_replies [$];  // predicted replies, oldest first
  logic [31:0]  stored_keys [$];  // keys sent with an insert, reused for lookups

  // beat counters, updated with nonblocking writes so the sequencer reads them race-free
  int     beats_in  = 0;
  int     beats_out = 0;
  logic   in_took   = 1'b0;       // input beat accepted at the last rising edge
  int     err_count = 0;

  // sequencer writes idling controls after a falling edge and holds after a rising one
  int     tx_idle_pct   = 18;
  int     rx_idle_pct   = 18;
  bit     sender_hold   = 1'b0;
  int     rx_hold_asked = 0;
  int     rx_hold_done  = 0;
  int     rx_hold_left  = 0;

  // run length guard: grows with every queued op by its worst-case cost
  longint run_budget  = 5000;
  longint cycle_count = 0;

  double_hash_table_engine u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_command      (in_command),
    .in_key          (in_key),
    .in_payload      (in_payload),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_slot        (out_slot),
    .out_payload_out (out_payload_out),
    .cfg_psel        (cfg_psel),
    .cfg_penable     (cfg_penable),
    .cfg_pwrite      (cfg_pwrite),
    .cfg_paddr       (cfg_paddr),
    .cfg_pwdata      (cfg_pwdata),
    .cfg_prdata      (cfg_prdata),
    .cfg_pready      (cfg_pready)
  );

  always #5 clk = ~clk;

  task automatic note_error(input string msg);
    $display("tb error @%0t: %s", $realtime, msg);
    err_count++;
  endtask

  // size and limit as the block applies them: zero acts as one, size clamps to capacity
  function automatic longint unsigned eff_size();
    if (cur_size == 0) begin
      return 1;
    end
    if (cur_size > CAPACITY) begin
      return CAPACITY;
    end
    return cur_size;
  endfunction

  function automatic longint unsigned eff_limit();
    return (cur_limit == 0) ? 1 : cur_limit;
  endfunction

  // walk the probe sequence for one op, update the shadow table, return the reply
  function automatic table_reply_t hash_probe(input logic cmd, input logic [31:0] key,
                                              input logic [31:0] data);
    table_reply_t r;
    longint unsigned s, lim, prime, step, h, kv, i, lo;
    int unsigned band_tab [9] = '{2, 3, 5, 7, 23, 53, 97, 193, 389};
    s   = eff_size();
    lim = eff_limit();
    kv  = key;
    // prime from the power-of-two band of the size; a size of one has no band
    prime = 64'd1610612741;
    for (int n = 9; n >= 1; n--) begin
      lo = 64'd1 << n;
      if (s >= lo && s <= (lo << 1)) begin
        prime = band_tab[n-1];
      end
    end
    step = (prime - (kv % prime)) % s;
    h    = kv % s;
    r.status = (cmd == CMD_INSERT) ? STAT_FULL : STAT_NOT_FOUND;
    r.slot   = '0;
    r.data   = '0;
    for (i = 1; i <= lim; i++) begin
      if (cmd == CMD_INSERT && !tbl_valid[h]) begin
        // first empty slot wins, duplicates are not checked
        tbl_valid[h] = 1'b1;
        tbl_key[h]   = key;
        tbl_data[h]  = data;
        r.status = STAT_STORED;
        r.slot   = h[SLOT_W-1:0];
        return r;
      end
      if (cmd == CMD_LOOKUP && tbl_valid[h] && tbl_key[h] == key) begin
        r.status = STAT_FOUND;
        r.slot   = h[SLOT_W-1:0];
        r.data   = tbl_data[h];
        return r;
      end
      // empty slots do not end a lookup
      h = (h + (i % s) * step) % s;
    end
    return r;
  endfunction

  task automatic add_op(input logic cmd, input logic [31:0] key, input logic [31:0] data);
    queued_ops.push_back('{cmd: cmd, key: key, data: data});
    run_budget += 200 + 4 * eff_limit();
    if (cmd == CMD_INSERT) begin
      stored_keys.push_back(key);
    end
  endtask

  // key mix: colliding multiples of the size, values near both ends, fully random
  function automatic logic [31:0] pick_key();
    case ($urandom_range(0, 9))
      0: return 32'($urandom_range(0, 15) * eff_size() + $urandom_range(0, 2));
      1: return 32'hFFFF_FFFF - $urandom_range(0, 15);
      2: return 32'($urandom_range(0, 15));
      default: return $urandom();
    endcase
  endfunction

  // apb write, then read back; the shadow register follows at the write edge
  task automatic cfg_write(input logic reg_idx, input logic [CFG_W-1:0] value);
    logic [31:0] wdata;
    wdata = {($urandom_range(0, 1) != 0) ? 21'($urandom()) : 21'd0, value};
    run_budget += 20;
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {reg_idx, 2'b00};
    cfg_pwdata  <= wdata;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (reg_idx == REG_TABLE_SIZE) begin
      cur_size = value;
    end else begin
      cur_limit = value;
    end
    @(negedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    if (cfg_prdata !== {21'd0, value}) begin
      note_error($sformatf("reg %0d read back %0h, wrote %0h", reg_idx, cfg_prdata, value));
    end
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // block is idle once nothing is queued, nothing is offered and every reply is in
  task automatic wait_idle();
    @(posedge clk);
    while (queued_ops.size() != 0 || in_valid || beats_in != beats_out) @(posedge clk);
  endtask

  // driver: a fresh beat goes out only after the previous one was taken or none was up
  always @(negedge clk) begin : drv_blk
    table_op_t op;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (queued_ops.size() != 0 && !sender_hold && $urandom_range(0, 99) >= tx_idle_pct) begin
        op = queued_ops.pop_front();
        in_valid   <= 1'b1;
        in_command <= op.cmd;
        in_key     <= op.key;
        in_payload <= op.data;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random idling, plus a long hold-off whenever the sequencer asks for one
  always @(negedge clk) begin
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_ready <= 1'b0;
    end else if (rx_hold_asked != rx_hold_done) begin
      rx_hold_done++;
      rx_hold_left = RX_HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= rst_n && ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // monitor: checks the reply beat against the oldest prediction, predicts the input beat
  always @(posedge clk) begin : mon_blk
    table_reply_t want;
    if (!rst_n) begin
      in_took <= 1'b0;
    end else begin
      in_took <= in_valid && in_ready;
      if (out_valid && out_ready) begin
        if (due_replies.size() == 0) begin
          note_error($sformatf("reply beat with nothing due: status %0d slot %0d",
                               out_status, out_slot));
        end else begin
          beats_out <= beats_out + 1;
          want = due_replies.pop_front();
          if (out_status !== want.status) begin
            note_error($sformatf("status %0d, want %0d", out_status, want.status));
          end
          if (out_slot !== want.slot) begin
            note_error($sformatf("slot %0d, want %0d", out_slot, want.slot));
          end
          if (out_payload_out !== want.data) begin
            note_error($sformatf("payload %08h, want %08h", out_payload_out, want.data));
          end
        end
      end
      if (in_valid && in_ready) begin
        beats_in <= beats_in + 1;
        due_replies.push_back(hash_probe(in_command, in_key, in_payload));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 3 * run_budget) begin
      $display("double_hash_table_engine_tb: done, errors");
      $finish;
    end
  end

  initial begin : seq_blk
    int n, r;
    logic [CFG_W-1:0] sz, lm;
    logic [31:0] key;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed, reset config: extremes, a collision, a duplicate, a miss over all probes
    add_op(CMD_INSERT, 32'h0000_0000, 32'h0000_0000);
    add_op(CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_op(CMD_INSERT, 32'd1024, 32'h0000_000C);      // same home slot as key zero
    add_op(CMD_INSERT, 32'h0000_0000, 32'h5555_5555); // duplicate key lands further on
    add_op(CMD_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);
    add_op(CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
    add_op(CMD_LOOKUP, 32'd1024, 32'h0);
    add_op(CMD_LOOKUP, 32'hDEAD_0000, 32'h0);         // absent: runs the whole limit
    add_op(CMD_INSERT, 32'hAAAA_AAAA, 32'h5555_5555);
    add_op(CMD_INSERT, 32'h5555_5555, 32'hAAAA_AAAA);
    add_op(CMD_LOOKUP, 32'hAAAA_AAAA, 32'h0);
    add_op(CMD_LOOKUP, 32'h5555_5555, 32'h0);
    wait_idle();

    // zero size and zero limit both act as one: single slot, single probe
    cfg_write(REG_TABLE_SIZE, 11'd0);
    cfg_write(REG_PROBE_LIMIT, 11'd0);
    add_op(CMD_INSERT, 32'd77, 32'h1234_5678);        // slot zero taken: table full
    add_op(CMD_LOOKUP, 32'h0000_0000, 32'h0);
    add_op(CMD_LOOKUP, 32'd1, 32'h0);
    wait_idle();

    // oversize clamps to capacity, widest limit
    cfg_write(REG_TABLE_SIZE, 11'd2047);
    cfg_write(REG_PROBE_LIMIT, 11'd2047);
    add_op(CMD_LOOKUP, 32'd1024, 32'h0);
    add_op(CMD_LOOKUP, 32'h1234_5678, 32'h0);
    wait_idle();

    // tiny table: fills after a couple of inserts
    cfg_write(REG_TABLE_SIZE, 11'd3);
    cfg_write(REG_PROBE_LIMIT, 11'd5);
    for (int k = 1; k <= 4; k++) begin
      add_op(CMD_INSERT, 32'(3 * k), $urandom());
    end
    add_op(CMD_LOOKUP, 32'd6, 32'h0);
    wait_idle();

    // random phases, each under its own size and limit
    for (int ph = 0; ph < 12; ph++) begin
      case (ph % 6)
        0: sz = 11'($urandom_range(1, 16));
        1: sz = 11'($urandom_range(17, 1024));
        2: sz = 11'd1024;
        3: sz = 11'($urandom_range(1025, 2047));
        4: sz = 11'($urandom_range(2, 64));
        default: sz = (ph == 5) ? 11'd1 : 11'($urandom_range(0, 300));
      endcase
      case (ph)
        3: lm = 11'd1024;
        7: lm = 11'd0;
        9: lm = 11'd2047;
        default: lm = 11'($urandom_range(1, 48));
      endcase
      cfg_write(REG_TABLE_SIZE, sz);
      cfg_write(REG_PROBE_LIMIT, lm);
      // one stretch with no idling on either side
      tx_idle_pct = (ph == 4) ? 0 : 18;
      rx_idle_pct = (ph == 4) ? 0 : 18;
      // big limits make misses expensive, so those phases stay short
      n = (ph == 3 || ph == 9) ? 30 : 74;
      for (int k = 0; k < n; k++) begin
        r = $urandom_range(0, 99);
        if (r < 45) begin
          key = (r < 6 && stored_keys.size() != 0) ?
                stored_keys[$urandom_range(0, stored_keys.size() - 1)] : pick_key();
          add_op(CMD_INSERT, key, $urandom());
        end else if (r < 85 && stored_keys.size() != 0) begin
          add_op(CMD_LOOKUP, stored_keys[$urandom_range(0, stored_keys.size() - 1)],
                 $urandom());
        end else begin
          add_op(CMD_LOOKUP, pick_key(), $urandom());
        end
      end
      @(posedge clk);
      if (ph == 2) begin
        // receiver stalls while the sender keeps offering beats
        run_budget += RX_HOLD_CYCLES;
        rx_hold_asked++;
      end
      if (ph == 6) begin
        // sender stops halfway and lets every reply drain before going on
        while (queued_ops.size() > n / 2) @(posedge clk);
        sender_hold = 1'b1;
        while (in_valid || beats_in != beats_out) @(posedge clk);
        repeat ($urandom_range(5, 40)) @(posedge clk);
        sender_hold = 1'b0;
      end
      wait_idle();
    end

    // settle time in case anything stray comes out
    repeat (100 + 2 * eff_limit()) @(posedge clk);
    if (err_count == 0) begin
      $display("double_hash_table_engine_tb: done, clean");
    end else begin
      $display("double_hash_table_engine_tb: done, errors");
    end
    $finish;
  end

endmodule
